[design/reb_pkg.sv]
// ----------------------------------------------------------------------------
// reb_pkg
// Shared constants, controller state codes and control/status bundles for the
// RR ectopic beat filter.
// ----------------------------------------------------------------------------
package reb_pkg;

    localparam int DETECT_HALF_WINDOW_DEF  = 20;
    localparam int REPLACE_HALF_WINDOW_DEF = 4;

    localparam int VALUE_W = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [VALUE_W-1:0] RANGE_LOW_RESET  = 20'd3200;
    localparam logic [VALUE_W-1:0] RANGE_HIGH_RESET = 20'd64000;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b000_0000_0001,
        ST_RD_MID   = 11'b000_0000_0010,
        ST_RD_OLD   = 11'b000_0000_0100,
        ST_UPD      = 11'b000_0000_1000,
        ST_MARK     = 11'b000_0001_0000,
        ST_EMIT_RD  = 11'b000_0010_0000,
        ST_EMIT_CHK = 11'b000_0100_0000,
        ST_SCAN_RD  = 11'b000_1000_0000,
        ST_SCAN_ACC = 11'b001_0000_0000,
        ST_DIV_CHK  = 11'b010_0000_0000,
        ST_DIV      = 11'b100_0000_0000
    } reb_state_t;

    typedef struct packed {
        logic accept;
        logic rd_mid;
        logic rd_old;
        logic upd;
        logic mark;
        logic emit_rd;
        logic emit_chk;
        logic scan_rd;
        logic scan_acc;
        logic div_init;
        logic div_step;
        logic out_load;
    } reb_cmd_t;

    typedef struct packed {
        logic has_emit;
        logic replace;
        logic scan_done;
        logic sum_zero;
        logic div_done;
        logic out_free;
        logic more;
    } reb_status_t;

endpackage

[design/reb_ctrl.sv]
// ----------------------------------------------------------------------------
// reb_ctrl
// Sequencer for the filter: one item at a time through history update,
// marking, and the emit / replace / divide loop.
// ----------------------------------------------------------------------------
module reb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  reb_pkg::reb_status_t status,
    output reb_pkg::reb_cmd_t    cmd
);
    import reb_pkg::*;

    reb_state_t state_reg;
    reb_state_t state_next;
    logic       out_wait;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE) || out_wait;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        out_wait   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_RD_MID;
                end
            end
            ST_RD_MID:
            begin
                cmd.rd_mid = 1'b1;
                state_next = ST_RD_OLD;
            end
            ST_RD_OLD:
            begin
                cmd.rd_old = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = status.has_emit ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_CHK;
            end
            ST_EMIT_CHK:
            begin
                cmd.emit_chk = 1'b1;
                // replaced beats scan their neighborhood first
                if (status.replace)
                begin
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    state_next = ST_DIV_CHK;
                end
            end
            ST_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_ACC;
            end
            ST_SCAN_ACC:
            begin
                cmd.scan_acc = 1'b1;
                state_next   = status.scan_done ? ST_DIV_CHK : ST_SCAN_RD;
            end
            ST_DIV_CHK:
            begin
                // plain beats and zero-sum replacements go straight out;
                // hold the result here until the output register frees up
                if (status.sum_zero)
                begin
                    if (status.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = status.more ? ST_EMIT_RD : ST_IDLE;
                    end
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!status.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = status.more ? ST_EMIT_RD : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/reb_datapath.sv]
// ----------------------------------------------------------------------------
// reb_datapath
// History memory, outlier marks, window sums, replacement accumulator,
// serial divider and output register.
// ----------------------------------------------------------------------------
module reb_datapath #(
    parameter int DETECT_HALF_WINDOW  = reb_pkg::DETECT_HALF_WINDOW_DEF,
    parameter int REPLACE_HALF_WINDOW = reb_pkg::REPLACE_HALF_WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [reb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [reb_pkg::VALUE_W-1:0]       cfg_data,
    input  logic [reb_pkg::VALUE_W-1:0]       rr_interval,
    input  logic                              end_of_record,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [reb_pkg::VALUE_W-1:0]       corrected_interval,
    output logic                              was_replaced,
    output logic                              final_result,
    input  reb_pkg::reb_cmd_t                 cmd,
    output reb_pkg::reb_status_t              status
);
    import reb_pkg::*;

    localparam int D       = DETECT_HALF_WINDOW;
    localparam int R       = REPLACE_HALF_WINDOW;
    localparam int DEPTH   = 2 * D + 2 * R + 1;
    localparam int LAG     = D + R;
    localparam int CAP     = DEPTH + 1;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(CAP + 1);
    localparam int WSUM_W  = VALUE_W + $clog2(D + 1);
    localparam int SUM_W   = VALUE_W + $clog2(2 * R + 1);
    localparam int N_W     = $clog2(2 * R + 2);
    localparam int CMP_W   = VALUE_W + $clog2(24 * D) + 1;
    localparam int DCNT_W  = $clog2(SUM_W);

    localparam logic [ADDR_W-1:0] BACK_MID  = ADDR_W'(D);
    localparam logic [ADDR_W-1:0] BACK_OLD  = ADDR_W'(2 * D + 1);
    localparam logic [ADDR_W-1:0] BACK_LAG  = ADDR_W'(LAG);
    localparam logic [ADDR_W-1:0] BACK_R    = ADDR_W'(R);
    localparam logic [ADDR_W-1:0] WP_LAST   = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0]  J_MID     = CNT_W'(D);
    localparam logic [CNT_W-1:0]  J_OLD     = CNT_W'(2 * D + 1);
    localparam logic [CNT_W-1:0]  J_MARK    = CNT_W'(2 * D);
    localparam logic [CNT_W-1:0]  J_LAG     = CNT_W'(LAG);
    localparam logic [CNT_W-1:0]  J_R       = CNT_W'(R);
    localparam logic [CNT_W-1:0]  J_CAP     = CNT_W'(CAP);
    localparam logic [CMP_W-1:0]  SCALE_X   = CMP_W'(20 * D);
    localparam logic [N_W-1:0]    N_MAX     = N_W'(2 * R + 1);
    localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(SUM_W - 1);

    function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] wp,
                                              input logic [ADDR_W-1:0] back);
        logic [ADDR_W:0] t;
        if (wp >= back)
        begin
            t = {1'b0, wp} - {1'b0, back};
        end
        else
        begin
            t = {1'b0, wp} + DEPTH_X - {1'b0, back};
        end
        return t[ADDR_W-1:0];
    endfunction

    logic [VALUE_W-1:0] hist_mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;

    logic [VALUE_W-1:0] low_reg, high_reg;
    logic [ADDR_W-1:0]  wp_reg, wp_next;
    logic [CNT_W-1:0]   count_reg, j_reg;
    logic               last_reg;
    logic [VALUE_W-1:0] new_reg, mid_reg;
    logic [WSUM_W-1:0]  right_reg, left_reg;
    logic [DEPTH-1:0]   mark_reg;
    logic [ADDR_W-1:0]  back_reg, scan_reg;
    logic [VALUE_W-1:0] value_reg, prev_reg;
    logic               rep_reg;
    logic [SUM_W-1:0]   acc_reg, quo_reg, quo_next;
    logic [N_W-1:0]     n_reg;
    logic [N_W-1:0]     rem_reg;
    logic [N_W:0]       rem_shift, rem_next;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic               ovalid_reg;
    logic [VALUE_W-1:0] oval_reg;
    logic               orep_reg, ofin_reg;
    logic               orep_src;

    logic [WSUM_W-1:0]  mid_term, old_term;
    logic [WSUM_W:0]    win_sum;
    logic [CMP_W-1:0]   scaled, hi_lim, lo_lim;
    logic               bad;
    logic [CNT_W-1:0]   j_minus_back;
    logic               more;
    logic [VALUE_W-1:0] load_value;

    assign wp_next = (wp_reg == WP_LAST) ? '0 : wp_reg + 1'b1;

    always_comb
    begin
        rd_addr = slot(wp_reg, scan_reg);
        if (cmd.rd_mid)
        begin
            rd_addr = slot(wp_reg, BACK_MID);
        end
        else if (cmd.rd_old)
        begin
            rd_addr = slot(wp_reg, BACK_OLD);
        end
        else if (cmd.emit_rd)
        begin
            rd_addr = slot(wp_reg, back_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hist_mem[wp_next] <= rr_interval;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // window terms: only beats that exist in this record enter or leave
    assign mid_term = (j_reg >= J_MID) ? WSUM_W'(mid_reg) : '0;
    assign old_term = (j_reg >= J_OLD) ? WSUM_W'(rd_data_reg) : '0;

    // left sum runs from the center beat outward, so take the center back out
    assign win_sum = {1'b0, left_reg} + {1'b0, right_reg} - (WSUM_W + 1)'(mid_reg);
    assign scaled  = CMP_W'(mid_reg) * SCALE_X;
    assign hi_lim  = CMP_W'({win_sum, 3'b000}) + CMP_W'({win_sum, 2'b00});
    assign lo_lim  = CMP_W'({win_sum, 3'b000});
    assign bad     = (mid_reg < low_reg) || (mid_reg > high_reg) ||
                     (scaled > hi_lim) || (scaled < lo_lim);

    assign j_minus_back = j_reg - CNT_W'(back_reg);
    assign more         = last_reg && (back_reg != '0);

    // a replaced beat whose neighbors sum to zero repeats the previous result
    assign load_value = (rep_reg && (acc_reg == '0)) ? prev_reg : value_reg;

    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    always_comb
    begin
        quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        rem_next = rem_shift;
        if (rem_shift >= {1'b0, n_reg})
        begin
            rem_next    = rem_shift - {1'b0, n_reg};
            quo_next[0] = 1'b1;
        end
    end

    assign status.has_emit  = (j_reg >= J_LAG) || last_reg;
    assign status.replace   = mark_reg[slot(wp_reg, back_reg)] && (back_reg >= BACK_R) &&
                              (j_minus_back >= J_R);
    assign status.scan_done = (scan_reg == back_reg + BACK_R);
    assign status.sum_zero  = !rep_reg || (acc_reg == '0);
    assign status.div_done  = (dcnt_reg == DCNT_LAST) && !rep_reg;
    assign status.out_free  = !ovalid_reg || !out_stall;
    assign status.more      = more;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg    <= RANGE_LOW_RESET;
            high_reg   <= RANGE_HIGH_RESET;
            wp_reg     <= WP_LAST;
            count_reg  <= '0;
            right_reg  <= '0;
            left_reg   <= '0;
            mark_reg   <= '0;
            prev_reg   <= '0;
            ovalid_reg <= 1'b0;
            last_reg   <= 1'b0;
            j_reg      <= '0;
            back_reg   <= '0;
            scan_reg   <= '0;
            rep_reg    <= 1'b0;
            n_reg      <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RANGE_LOW:  low_reg  <= cfg_data;
                    REG_RANGE_HIGH: high_reg <= cfg_data;
                    default:        ;
                endcase
            end

            if (cmd.accept)
            begin
                wp_reg           <= wp_next;
                mark_reg[wp_next] <= 1'b0;
                j_reg            <= count_reg;
                last_reg         <= end_of_record;
                if (count_reg < J_CAP)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end

            if (cmd.upd)
            begin
                right_reg <= right_reg + WSUM_W'(new_reg) - mid_term;
                left_reg  <= left_reg + mid_term - old_term;
            end

            if (cmd.mark)
            begin
                if (j_reg >= J_MARK)
                begin
                    mark_reg[slot(wp_reg, BACK_MID)] <= bad;
                end
                back_reg <= (j_reg >= J_LAG) ? BACK_LAG : j_reg[ADDR_W-1:0];
            end

            if (cmd.emit_chk)
            begin
                rep_reg  <= status.replace;
                scan_reg <= back_reg - BACK_R;
                n_reg    <= '0;
            end

            if (cmd.scan_acc)
            begin
                if (!mark_reg[slot(wp_reg, scan_reg)])
                begin
                    n_reg <= n_reg + 1'b1;
                end
                scan_reg <= scan_reg + 1'b1;
            end

            if (cmd.div_init)
            begin
                dcnt_reg <= '0;
                rep_reg  <= 1'b1;
            end

            if (cmd.div_step)
            begin
                // flag last step through rep_reg so div_done rises after it
                if (dcnt_reg == DCNT_LAST)
                begin
                    rep_reg <= 1'b0;
                end
                else
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
            end

            if (cmd.out_load)
            begin
                ovalid_reg <= 1'b1;
                if (more)
                begin
                    back_reg <= back_reg - 1'b1;
                    prev_reg <= load_value;
                end
                else if (last_reg)
                begin
                    // end of record: stream state back to reset values
                    wp_reg    <= WP_LAST;
                    count_reg <= '0;
                    right_reg <= '0;
                    left_reg  <= '0;
                    mark_reg  <= '0;
                    prev_reg  <= '0;
                end
                else
                begin
                    prev_reg <= load_value;
                end
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            new_reg <= rr_interval;
        end
        if (cmd.rd_old)
        begin
            mid_reg <= rd_data_reg;
        end
        if (cmd.emit_chk)
        begin
            value_reg <= rd_data_reg;
            acc_reg   <= '0;
            orep_src  <= status.replace;
        end
        if (cmd.scan_acc && !mark_reg[slot(wp_reg, scan_reg)])
        begin
            acc_reg <= acc_reg + SUM_W'(rd_data_reg);
        end
        if (cmd.div_init)
        begin
            quo_reg <= acc_reg;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next[N_W-1:0];
            if (dcnt_reg == DCNT_LAST)
            begin
                value_reg <= quo_next[VALUE_W-1:0];
            end
        end
        if (cmd.out_load)
        begin
            oval_reg <= load_value;
            orep_reg <= orep_src;
            ofin_reg <= last_reg && (back_reg == '0);
        end
    end

    assign out_valid          = ovalid_reg;
    assign corrected_interval = oval_reg;
    assign was_replaced       = orep_reg;
    assign final_result       = ofin_reg;

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a held result");

    a_wp_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (wp_reg != $past(wp_reg)))
        else $error("history pointer did not advance");

    a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_MAX)
        else $error("replacement count out of window");

    a_fresh_record: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && (count_reg == '0)) |=> (mark_reg == '0))
        else $error("marks left over from previous record");
`endif

endmodule

[design/rr_ectopic_beat_filter.sv]
// ----------------------------------------------------------------------------
// rr_ectopic_beat_filter
// Outlier marking and moving-average replacement of RR intervals.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one raw interval and an
// end_of_record flag; output channel (out_valid / out_stall) carries one
// corrected interval with was_replaced and final_result flags.
// Configuration: cfg_write with cfg_index 0 writes range_low, 1 range_high;
// write only while the block is idle.
// Results lag the input by DETECT_HALF_WINDOW + REPLACE_HALF_WINDOW beats;
// end_of_record flushes every remaining beat of the record, the last one
// flagged final_result, and the stream state returns to its reset values.
// An item reads the center and oldest window beats, updates the window sums
// and marks the center; an item that emits a beat reads and checks it, and a
// replaced beat first scans its history neighborhood and, unless its neighbors
// sum to zero, runs the serial divider before the result goes out.
// A flush emits up to LAG+1 results, each through the same loop, set by the
// single read port of the history memory.
// in_stall is high while an item is in work. A stalled output holds its
// result; the next item runs until it needs the output register.
// Reset is asynchronous: state registers go to defaults, payload registers and history need no clear.
// ----------------------------------------------------------------------------
module rr_ectopic_beat_filter #(
    parameter int DETECT_HALF_WINDOW  = reb_pkg::DETECT_HALF_WINDOW_DEF,
    parameter int REPLACE_HALF_WINDOW = reb_pkg::REPLACE_HALF_WINDOW_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [reb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [reb_pkg::VALUE_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [reb_pkg::VALUE_W-1:0]   rr_interval,
    input  logic                          end_of_record,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [reb_pkg::VALUE_W-1:0]   corrected_interval,
    output logic                          was_replaced,
    output logic                          final_result
);
    import reb_pkg::*;

    reb_cmd_t    cmd;
    reb_status_t status;

    reb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    reb_datapath #(
        .DETECT_HALF_WINDOW  (DETECT_HALF_WINDOW),
        .REPLACE_HALF_WINDOW (REPLACE_HALF_WINDOW)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .rr_interval        (rr_interval),
        .end_of_record      (end_of_record),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .corrected_interval (corrected_interval),
        .was_replaced       (was_replaced),
        .final_result       (final_result),
        .cmd                (cmd),
        .status             (status)
    );

endmodule
